// ----- sv/assert_macros.svh -----
// Assertion macros shared by the accumulator execute block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising clock edge outside reset
`define ACPU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication: when ante holds, cons must hold in the same cycle
`define ACPU_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- sv/acpu_pkg.sv -----
// Types and constants of the accumulator execute block
`timescale 1ns / 1ps
package acpu_pkg;

  localparam logic [7:0] BYTE_MAX = 8'd255;

  typedef enum logic [7:0] {
    OP_LOAD_MEM = 8'd0,
    OP_LOAD_VAL = 8'd1,
    OP_STORE    = 8'd2,
    OP_ADD      = 8'd3,
    OP_SUB      = 8'd4,
    OP_MUL      = 8'd5,
    OP_DIV      = 8'd6,
    OP_INC      = 8'd7,
    OP_DEC      = 8'd8,
    OP_AND      = 8'd9,
    OP_OR       = 8'd10,
    OP_NOT      = 8'd11,
    OP_JMP      = 8'd12,
    OP_JZ       = 8'd13,
    OP_JNZ      = 8'd14,
    OP_JG       = 8'd15,
    OP_JL       = 8'd16,
    OP_JGE      = 8'd17,
    OP_JLE      = 8'd18,
    OP_HLT      = 8'd19
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // latch the incoming transaction
    logic mem_rd;     // read data memory at the operand address
    logic div_start;  // load the divider
    logic div_step;   // one restoring divide step
    logic commit;     // update machine state and the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_op;
    logic stopped;
  } sts_t;

endpackage

// ----- sv/acpu_if.sv -----
// Handshake interfaces for the instruction and result channels
`timescale 1ns / 1ps
interface acpu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] opcode;
  logic [7:0] operand;

  modport source (output valid, output opcode, output operand, input ready);
  modport sink   (input valid, input opcode, input operand, output ready);
endinterface

interface acpu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] next_pc;
  logic [7:0] acc_value;
  logic       zero_flag;
  logic       carry_flag;
  logic       overflow_flag;
  logic       halted;
  logic       divide_error;

  modport source (output valid, output next_pc, output acc_value, output zero_flag,
                  output carry_flag, output overflow_flag, output halted,
                  output divide_error, input ready);
  modport sink   (input valid, input next_pc, input acc_value, input zero_flag,
                  input carry_flag, input overflow_flag, input halted,
                  input divide_error, output ready);
endinterface

// ----- sv/accumulator_cpu_execute.sv -----
// Top level of the accumulator machine execute block
`timescale 1ns / 1ps
// Executes one (opcode, operand) transaction of an 8-bit accumulator machine and
// returns one result transaction: next instruction index, accumulator and status
// bits. The block holds the accumulator, the instruction pointer, a MEM_DEPTH-byte
// data memory that reads as zero after reset, and a halted flag. A transaction is
// accepted, then goes through memory read, execute and commit before the next is
// accepted; a divide adds eight steps of the one-bit-a-step restoring divider
// between execute and commit. The result sits in an output register, so a new
// transaction is taken while the previous result still waits; commit holds only
// until that register is free. Reset is synchronous and active low; it leaves the
// memory contents alone but clears a valid bit per entry, so no clearing pass is
// needed.
module accumulator_cpu_execute
  import acpu_pkg::*;
#(
  parameter int MEM_DEPTH = 256
) (
  input logic          clk,
  input logic          rst_n,
  acpu_in_if.sink      in_ch,
  acpu_out_if.source   out_ch
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer: handshakes and step order
  acpu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: state, memory, ALU, divider and result register
  acpu_dpath #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_opcode       (in_ch.opcode),
    .in_operand      (in_ch.operand),
    .o_next_pc       (out_ch.next_pc),
    .o_acc_value     (out_ch.acc_value),
    .o_zero_flag     (out_ch.zero_flag),
    .o_carry_flag    (out_ch.carry_flag),
    .o_overflow_flag (out_ch.overflow_flag),
    .o_halted        (out_ch.halted),
    .o_divide_error  (out_ch.divide_error)
  );

endmodule

// ----- sv/acpu_ctrl.sv -----
// Sequencing state machine of the accumulator execute block
`timescale 1ns / 1ps
`include "assert_macros.svh"
module acpu_ctrl
  import acpu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        // hold off new transactions while reset is applied
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_READ;
        end
      end
      ST_READ: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.div_op && !sts.stopped) begin
          cmd.div_start = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = ST_DIVIDE;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

  `ACPU_ASSERT_IMP(a_commit_free, cmd.commit, !out_valid_r || out_ready, "result overwritten")
  `ACPU_ASSERT(a_accept_reads, (in_valid && in_ready) |=> (state_r == ST_READ), "no read after accept")
  `ACPU_ASSERT_IMP(a_valid_rise, $rose(out_valid_r), $past(cmd.commit), "result without commit")

endmodule

// ----- sv/acpu_dpath.sv -----
// Datapath: machine state, data memory, ALU, divider and result register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module acpu_dpath
  import acpu_pkg::*;
#(
  parameter int MEM_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  logic [7:0] in_opcode,
  input  logic [7:0] in_operand,
  output logic [7:0] o_next_pc,
  output logic [7:0] o_acc_value,
  output logic       o_zero_flag,
  output logic       o_carry_flag,
  output logic       o_overflow_flag,
  output logic       o_halted,
  output logic       o_divide_error
);

  localparam int AW = $clog2(MEM_DEPTH);

  logic [7:0] op_r, arg_r;
  logic [7:0] acc_r, pc_r;
  logic       stopped_r;
  logic [7:0] mem_r [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vld_r;
  logic [7:0] rdata_r;
  logic       rvld_r;
  logic [7:0] rem_r, quo_r;
  logic [7:0] res_next_r, res_acc_r;
  logic       res_zf_r, res_cf_r, res_of_r, res_halt_r, res_de_r;

  logic [AW-1:0] addr;
  logic [7:0]    mval;
  logic [8:0]    shifted;
  logic [7:0]    seq, target;
  logic [8:0]    sum9;
  logic [15:0]   prod;
  logic [7:0]    nx_acc, nx_next;
  logic          nx_zf, nx_cf, nx_of, nx_de, set_zero;

  // Operand modulo the memory depth by conditional subtraction, exact while MEM_DEPTH is at least 16
  always_comb begin
    logic [11:0] r;
    r = {4'd0, arg_r};
    for (int k = 3; k >= 0; k--) begin
      if (r >= 12'(MEM_DEPTH << k)) begin
        r = r - 12'(MEM_DEPTH << k);
      end
    end
    addr = r[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_opcode;
      arg_r <= in_operand;
    end
  end

  // Data memory; entries never written read as zero
  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rdata_r <= mem_r[addr];
    end
    if (cmd.commit && !stopped_r && op_r == OP_STORE) begin
      mem_r[addr] <= acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (cmd.mem_rd) begin
        rvld_r <= vld_r[addr];
      end
      if (cmd.commit && !stopped_r && op_r == OP_STORE) begin
        vld_r[addr] <= 1'b1;
      end
    end
  end

  assign mval = rvld_r ? rdata_r : 8'd0;

  // Restoring divider, one quotient bit a step; zero divisor gives all ones
  assign shifted = {rem_r, quo_r[7]};
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= '0;
      quo_r <= acc_r;
    end else if (cmd.div_step) begin
      if (shifted >= {1'b0, mval}) begin
        rem_r <= 8'(shifted - {1'b0, mval});
        quo_r <= {quo_r[6:0], 1'b1};
      end else begin
        rem_r <= shifted[7:0];
        quo_r <= {quo_r[6:0], 1'b0};
      end
    end
  end

  assign seq    = pc_r + 8'd1;
  assign target = {1'b0, arg_r[7:1]};
  assign sum9   = {1'b0, acc_r} + {1'b0, mval};
  assign prod   = acc_r * mval;

  always_comb begin
    nx_acc   = acc_r;
    nx_next  = seq;
    nx_cf    = 1'b0;
    nx_of    = 1'b0;
    nx_de    = 1'b0;
    set_zero = 1'b1;
    unique case (op_r)
      OP_LOAD_MEM: nx_acc = mval;
      OP_LOAD_VAL: nx_acc = arg_r;
      OP_STORE:    set_zero = 1'b0;
      OP_ADD: begin
        nx_acc = sum9[7:0];
        nx_cf  = sum9[8];
      end
      OP_SUB: nx_acc = acc_r - mval;
      OP_MUL: begin
        nx_acc = prod[7:0];
        nx_of  = |prod[15:8];
      end
      OP_DIV: begin
        nx_acc = quo_r;
        nx_de  = (mval == 8'd0);
      end
      OP_INC: begin
        nx_acc = acc_r + 8'd1;
        nx_cf  = (acc_r == BYTE_MAX);
      end
      OP_DEC: nx_acc = acc_r - 8'd1;
      OP_AND: nx_acc = acc_r & mval;
      OP_OR:  nx_acc = acc_r | mval;
      OP_NOT: nx_acc = ~acc_r;
      OP_JMP, OP_JGE: begin
        nx_next  = target;
        set_zero = 1'b0;
      end
      OP_JZ, OP_JLE: begin
        nx_next  = (acc_r == 8'd0) ? target : seq;
        set_zero = 1'b0;
      end
      OP_JNZ, OP_JG: begin
        nx_next  = (acc_r != 8'd0) ? target : seq;
        set_zero = 1'b0;
      end
      OP_JL: set_zero = 1'b0;
      OP_HLT: begin
        nx_next  = pc_r;
        set_zero = 1'b0;
      end
      default: set_zero = 1'b0;
    endcase
    nx_zf = set_zero && (nx_acc == 8'd0);
  end

  // Machine state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      pc_r      <= '0;
      stopped_r <= 1'b0;
    end else if (cmd.commit && !stopped_r) begin
      acc_r <= nx_acc;
      pc_r  <= nx_next;
      if (op_r == OP_HLT) begin
        stopped_r <= 1'b1;
      end
    end
  end

  // Result register; a stopped machine repeats its state
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (stopped_r) begin
        res_next_r <= pc_r;
        res_acc_r  <= acc_r;
        res_zf_r   <= 1'b0;
        res_cf_r   <= 1'b0;
        res_of_r   <= 1'b0;
        res_halt_r <= 1'b1;
        res_de_r   <= 1'b0;
      end else begin
        res_next_r <= nx_next;
        res_acc_r  <= nx_acc;
        res_zf_r   <= nx_zf;
        res_cf_r   <= nx_cf;
        res_of_r   <= nx_of;
        res_halt_r <= (op_r == OP_HLT);
        res_de_r   <= nx_de;
      end
    end
  end

  assign sts.div_op      = (op_r == OP_DIV);
  assign sts.stopped     = stopped_r;
  assign o_next_pc       = res_next_r;
  assign o_acc_value     = res_acc_r;
  assign o_zero_flag     = res_zf_r;
  assign o_carry_flag    = res_cf_r;
  assign o_overflow_flag = res_of_r;
  assign o_halted        = res_halt_r;
  assign o_divide_error  = res_de_r;

  `ACPU_ASSERT(a_stop_sticks, stopped_r |=> stopped_r, "halted machine restarted")

endmodule

// ----- dv/tb_accumulator_cpu_execute.sv -----
// Self-checking testbench for the accumulator machine execute block
`timescale 1ns / 1ps
module tb_accumulator_cpu_execute;
  import acpu_pkg::*;

  localparam int MEM_DEPTH    = 256;
  localparam int CYCLE_LIMIT  = 200000;  // generous ceiling for the whole run
  localparam int DRAIN_CYCLES = 24;      // quiet time at the end of the run

  // One result transaction as the block presents it
  typedef struct packed {
    logic [7:0] next_pc;
    logic [7:0] acc_value;
    logic       zero_flag;
    logic       carry_flag;
    logic       overflow_flag;
    logic       halted;
    logic       divide_error;
  } exec_result_t;

  // One row of the directed stimulus table; fixed rows carry a hand-written result
  typedef struct packed {
    logic [7:0]   opcode;
    logic [7:0]   operand;
    logic         fixed;
    exec_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic rx_ready = 1'b0;

  acpu_in_if  in_ch ();
  acpu_out_if out_ch ();

  accumulator_cpu_execute #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 12 ns period: six high, six low
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Machine state as the predictor sees it
  logic [7:0] model_acc;
  logic [7:0] model_pc;
  logic [7:0] model_mem [MEM_DEPTH];
  logic       model_halted;

  exec_result_t pending_results [$];
  stim_row_t    directed_rows [$];

  int tx_idle_pct = 37;
  int rx_idle_pct = 79;
  int mismatches  = 0;
  int checked     = 0;
  int cycle_count = 0;

  // ---------------------------------------------------------------------------
  // Predictor: execute one instruction against the model state and return
  // the result transaction it produces.
  // ---------------------------------------------------------------------------
  function automatic exec_result_t execute_model(input logic [7:0] op, input logic [7:0] arg);
    exec_result_t r;
    logic [7:0]   seq;
    logic [7:0]   target;
    logic [7:0]   m;
    logic [15:0]  wide;
    r      = '0;
    seq    = model_pc + 8'd1;   // wraps from 255 to 0
    target = arg >> 1;          // byte target to instruction index
    m      = model_mem[arg % MEM_DEPTH];
    // A stopped machine ignores everything and repeats pc and accumulator
    if (model_halted) begin
      r.next_pc   = model_pc;
      r.acc_value = model_acc;
      r.halted    = 1'b1;
      return r;
    end
    r.next_pc = seq;
    case (op)
      OP_LOAD_MEM: model_acc = m;
      OP_LOAD_VAL: model_acc = arg;
      OP_STORE:    model_mem[arg % MEM_DEPTH] = model_acc;
      OP_ADD: begin
        wide         = {8'd0, model_acc} + {8'd0, m};
        r.carry_flag = (wide > 16'(BYTE_MAX));
        model_acc    = wide[7:0];
      end
      OP_SUB: model_acc = model_acc - m;
      OP_MUL: begin
        wide            = {8'd0, model_acc} * {8'd0, m};
        r.overflow_flag = (wide > 16'(BYTE_MAX));
        model_acc       = wide[7:0];
      end
      OP_DIV: begin
        if (m == 8'd0) begin
          model_acc      = BYTE_MAX;
          r.divide_error = 1'b1;
        end else begin
          model_acc = model_acc / m;
        end
      end
      OP_INC: begin
        r.carry_flag = (model_acc == BYTE_MAX);
        model_acc    = model_acc + 8'd1;
      end
      OP_DEC: model_acc = model_acc - 8'd1;
      OP_AND: model_acc = model_acc & m;
      OP_OR:  model_acc = model_acc | m;
      OP_NOT: model_acc = ~model_acc;
      OP_JMP, OP_JGE: r.next_pc = target;
      // Unsigned compares: JLE is the same test as JZ, JG the same as JNZ
      OP_JZ, OP_JLE:  if (model_acc == 8'd0) r.next_pc = target;
      OP_JNZ, OP_JG:  if (model_acc != 8'd0) r.next_pc = target;
      OP_JL: ;        // never taken
      OP_HLT: begin
        model_halted = 1'b1;
        r.next_pc    = model_pc;
      end
      default: ;      // unknown opcode: advance only
    endcase
    // Zero flag comes only from load, arithmetic and logic instructions
    if (op <= OP_NOT && op != OP_STORE) r.zero_flag = (model_acc == 8'd0);
    model_pc    = r.next_pc;
    r.acc_value = model_acc;
    r.halted    = model_halted;
    return r;
  endfunction

  // Random opcode: mostly defined instructions, weighted towards stores and
  // immediate loads so that memory fills up; halt is held back for the end.
  function automatic logic [7:0] pick_opcode(input bit no_jumps);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return 8'($urandom_range(int'(OP_HLT) + 1, 255));
    if (sel < 25) return OP_STORE;
    if (sel < 35) return OP_LOAD_VAL;
    if (no_jumps) return 8'($urandom_range(0, int'(OP_NOT)));
    return 8'($urandom_range(0, int'(OP_JLE)));
  endfunction

  // Random operand: a small window of addresses most of the time, so that
  // stored values are read back, and the full byte range otherwise
  function automatic logic [7:0] pick_operand();
    if ($urandom_range(0, 99) < 60) return 8'($urandom_range(0, 15));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_row(input logic [7:0] op, input logic [7:0] arg);
    directed_rows.push_back('{opcode: op, operand: arg, fixed: 1'b0, want: '0});
  endtask

  task automatic add_fixed(input logic [7:0] op, input logic [7:0] arg,
                           input logic [7:0] pc, input logic [7:0] acc,
                           input logic z, input logic c, input logic o,
                           input logic h, input logic d);
    directed_rows.push_back('{opcode: op, operand: arg, fixed: 1'b1,
                              want: '{pc, acc, z, c, o, h, d}});
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch: result %0d: %s", checked, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Send one instruction transaction. Entered and left at a falling edge.
  // Idle first at the current rate, then hold valid until the block takes
  // the transaction, and only then advance the predictor.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [7:0] op, input logic [7:0] arg,
                           input logic fixed, input exec_result_t want);
    exec_result_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.opcode  <= op;
    in_ch.operand <= arg;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predicted = execute_model(op, arg);
    pending_results.push_back(fixed ? want : predicted);
    @(negedge clk);
  endtask

  // Drop valid and hold off until every expected result has come back.
  // Always wait for a falling edge first so valid gets one assignment per step.
  task automatic pause_until_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, changed at the falling edge
  // ---------------------------------------------------------------------------
  assign out_ch.ready = rx_ready;

  always @(negedge clk) begin
    rx_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Check each accepted result transaction against the oldest expectation
  always @(posedge clk) begin
    exec_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      checked++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("next_pc",       out_ch.next_pc,       want.next_pc);
        check_field("acc_value",     out_ch.acc_value,     want.acc_value);
        check_field("zero_flag",     8'(out_ch.zero_flag),     8'(want.zero_flag));
        check_field("carry_flag",    8'(out_ch.carry_flag),    8'(want.carry_flag));
        check_field("overflow_flag", 8'(out_ch.overflow_flag), 8'(want.overflow_flag));
        check_field("halted",        8'(out_ch.halted),        8'(want.halted));
        check_field("divide_error",  8'(out_ch.divide_error),  8'(want.divide_error));
      end
    end
  end

  // Watchdog: end the run if it stalls
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    in_ch.valid   = 1'b0;
    in_ch.opcode  = 8'd0;
    in_ch.operand = 8'd0;
    rst_n         = 1'b0;

    model_acc    = 8'd0;
    model_pc     = 8'd0;
    model_halted = 1'b0;
    foreach (model_mem[i]) model_mem[i] = 8'd0;

    // Directed table. Fixed rows follow straight from reset state and the
    // extremes; the rest go through the predictor.
    //          op           arg     pc     acc    z  c  o  h  d
    add_fixed(OP_LOAD_MEM, 8'h00, 8'd1, 8'd0,   1, 0, 0, 0, 0); // memory reads zero
    add_fixed(OP_LOAD_VAL, 8'hFF, 8'd2, 8'd255, 0, 0, 0, 0, 0);
    add_fixed(OP_STORE,    8'hFF, 8'd3, 8'd255, 0, 0, 0, 0, 0);
    add_fixed(OP_ADD,      8'hFF, 8'd4, 8'd254, 0, 1, 0, 0, 0); // 255 + 255 carries
    add_row  (OP_MUL,      8'hFF);                              // product overflows
    add_fixed(OP_DIV,      8'h80, 8'd6, 8'd255, 0, 0, 0, 0, 1); // divide by zero
    add_fixed(OP_INC,      8'h00, 8'd7, 8'd0,   1, 1, 0, 0, 0); // 255 + 1 wraps
    add_fixed(OP_DEC,      8'h00, 8'd8, 8'd255, 0, 0, 0, 0, 0); // 0 - 1 wraps
    add_row  (OP_STORE,    8'h01);
    add_row  (OP_DIV,      8'hFF);
    add_row  (OP_SUB,      8'h01);
    add_row  (OP_AND,      8'h01);
    add_row  (OP_OR,       8'h00);
    add_row  (OP_NOT,      8'h00);
    add_row  (OP_JZ,       8'h40);  // not taken, accumulator non-zero
    add_row  (OP_JNZ,      8'hFF);  // taken to the top jump target
    add_row  (OP_JG,       8'h00);  // taken to index zero
    add_row  (OP_JL,       8'hFE);  // never taken
    add_row  (OP_LOAD_VAL, 8'h00);
    add_row  (OP_JZ,       8'h21);  // taken, odd byte target rounds down
    add_row  (OP_JLE,      8'h0A);
    add_row  (OP_JGE,      8'h07);
    add_row  (OP_JG,       8'h30);  // not taken, accumulator zero
    add_row  (8'd20,       8'hAA);  // lowest unknown opcode
    add_row  (8'd255,      8'h55);  // highest unknown opcode
    add_row  (OP_JMP,      8'hFF);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].opcode, directed_rows[i].operand,
                directed_rows[i].fixed, directed_rows[i].want);
    end

    // Random part in three idling phases: slow receiver, then slow sender,
    // then full rate. Drain between phases so the sender pause is exercised.
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 79 : 0;
      rx_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 37 : 0;
      pause_until_drained();
      if (phase == 2) begin
        // Jump to the top index and run straight on, so the pc wraps past 255
        send_item(OP_JMP, 8'hFE, 1'b0, '0);
        repeat (140) send_item(pick_opcode(1'b1), pick_operand(), 1'b0, '0);
      end
      repeat ((phase == 2) ? 240 : 383) send_item(pick_opcode(1'b0), pick_operand(), 1'b0, '0);
    end

    // Halt last, since reset never comes again; then items the stopped
    // machine must ignore, halt among them
    pause_until_drained();
    send_item(OP_HLT, pick_operand(), 1'b0, '0);
    send_item(OP_HLT, 8'h00, 1'b0, '0);
    send_item(OP_LOAD_VAL, 8'hFF, 1'b0, '0);
    repeat (6) send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0, '0);
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/acpu_pkg.sv
sv/acpu_if.sv
sv/acpu_ctrl.sv
sv/acpu_dpath.sv
sv/accumulator_cpu_execute.sv
dv/tb_accumulator_cpu_execute.sv
